// ===== sv/tte_pkg.sv =====
// Package for the timer table: field widths, operation codes, the slot entry
// layout and the scan state type. No dependencies; used by timer_table_expiry and tte_cmp.
`timescale 1ns / 1ps

package tte_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int OP_W   = 2;
    localparam int SLOT_W = 4;
    localparam int IVL_W  = 16;
    localparam int TAG_W  = 16;
    localparam int TIME_W = 32;

    localparam int IN_RAW_W  = OP_W + SLOT_W + IVL_W + TAG_W + TIME_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = SLOT_W + TAG_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [IVL_W-1:0]  ivl;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ===== sv/timer_table_expiry.sv =====
// Timer table with expiry scan. Start and stop are accepted back to back.
// A check is accepted only from idle and closes the input until its scan of all
// slots ends, which takes longer while the result channel stalls; the scan is
// set by the single read port of the slot RAM and the one shared compare unit.
// Reset (aresetn low, synchronous) disarms every slot and empties the output.
`timescale 1ns / 1ps

module timer_table_expiry (
    input  logic                      aclk,
    input  logic                      aresetn,
    // s_tdata: op [1:0], slot [5:2], interval [21:6], event_tag [37:22],
    // now [69:38], zero fill above.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tte_pkg::IN_W-1:0]  s_tdata,
    // m_tdata: expired_slot [3:0], expired_tag [19:4], zero fill above.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [tte_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast
);
    import tte_pkg::*;

    // Input item fields, unpacked from the lowest bit up.
    logic [OP_W-1:0]   in_op;
    logic [SLOT_W-1:0] in_slot;
    logic [IVL_W-1:0]  in_ivl;
    logic [TAG_W-1:0]  in_tag;
    logic [TIME_W-1:0] in_now;

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_slot = s_tdata[OP_W +: SLOT_W];
    assign in_ivl  = s_tdata[OP_W + SLOT_W +: IVL_W];
    assign in_tag  = s_tdata[OP_W + SLOT_W + IVL_W +: TAG_W];
    assign in_now  = s_tdata[OP_W + SLOT_W + IVL_W + TAG_W +: TIME_W];

    state_t state_reg, state_next;

    logic             acc_in;
    logic             slot_ok;
    logic             start_wr;
    logic             stop_wr;
    logic             check_go;
    logic [IDX_W-1:0] wr_idx;

    // Armed bits stand in for a nonzero interval; reset clears them all, so
    // the RAM itself needs no clearing.
    logic [SLOTS-1:0] armed_reg, armed_next;

    // Scan pipeline: read issue, then evaluation of the returned entry.
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]  ev_idx_reg, ev_idx_next;
    logic [TIME_W-1:0] now_reg, now_next;

    // One expired slot is held back until the next one, or the end of the
    // scan, tells whether it is the last of the check.
    logic              pend_vld_reg, pend_vld_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [TAG_W-1:0]  pend_tag_reg, pend_tag_next;

    // Output register.
    logic              m_vld_reg, m_vld_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic [TAG_W-1:0]  m_tag_reg, m_tag_next;
    logic              m_last_reg, m_last_next;

    logic             scan_active;
    logic             rd_more;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic [ENTRY_W-1:0] rdata;
    entry_t           rd_entry;
    entry_t           wr_entry;
    logic             cmp_hit;
    logic             expired;
    logic             out_free;
    logic             ev_stall;
    logic             advance;
    logic             scan_end;
    logic             push_mid;
    logic             flush_push;
    logic             scan_done;

    assign acc_in   = s_tvalid && s_tready;
    assign slot_ok  = (int'(in_slot) < SLOTS);
    assign wr_idx   = IDX_W'(in_slot);
    assign start_wr = acc_in && (in_op == OP_START) && slot_ok;
    assign stop_wr  = acc_in && (in_op == OP_STOP) && slot_ok;
    assign check_go = acc_in && (in_op == OP_CHECK);

    assign wr_entry.start = in_now;
    assign wr_entry.ivl   = in_ivl;
    assign wr_entry.tag   = in_tag;

    tte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (start_wr),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_entry = entry_t'(rdata);

    tte_cmp u_cmp (
        .start (rd_entry.start),
        .ivl   (rd_entry.ivl),
        .now   (now_reg),
        .hit   (cmp_hit)
    );

    // Scan control. The evaluation stage stalls only when it finds an expiry
    // while a held result waits and the output register is still full.
    assign out_free   = !m_vld_reg || m_tready;
    assign rd_more    = (rd_cnt_reg < CNT_W'(SLOTS));
    assign expired    = ev_vld_reg && armed_reg[ev_idx_reg] && cmp_hit;
    assign ev_stall   = expired && pend_vld_reg && !out_free;
    assign advance    = scan_active && !ev_stall;
    assign re         = advance && rd_more;
    assign raddr      = rd_cnt_reg[IDX_W-1:0];
    assign scan_end   = scan_active && !rd_more && !ev_vld_reg;
    assign push_mid   = advance && expired && pend_vld_reg;
    assign flush_push = scan_end && pend_vld_reg && out_free;
    assign scan_done  = scan_end && (!pend_vld_reg || out_free);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (check_go) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: the input side is open only between scans.
    always_comb begin
        s_tready    = 1'b0;
        scan_active = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready    = 1'b1;
            ST_SCAN: scan_active = 1'b1;
            default: s_tready    = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb begin
        armed_next     = armed_reg;
        rd_cnt_next    = rd_cnt_reg;
        ev_vld_next    = ev_vld_reg;
        ev_idx_next    = ev_idx_reg;
        now_next       = now_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        pend_tag_next  = pend_tag_reg;
        m_vld_next     = m_vld_reg;
        m_slot_next    = m_slot_reg;
        m_tag_next     = m_tag_reg;
        m_last_next    = m_last_reg;

        if (start_wr) begin
            armed_next[wr_idx] = |in_ivl;
        end
        if (stop_wr) begin
            armed_next[wr_idx] = 1'b0;
        end

        if (check_go) begin
            rd_cnt_next = '0;
            now_next    = in_now;
        end else if (re) begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
        end

        if (advance) begin
            ev_vld_next = re;
            ev_idx_next = raddr;
            if (expired) begin
                armed_next[ev_idx_reg] = 1'b0;
                pend_vld_next          = 1'b1;
                pend_slot_next         = SLOT_W'(ev_idx_reg);
                pend_tag_next          = rd_entry.tag;
            end
        end
        if (flush_push) begin
            pend_vld_next = 1'b0;
        end

        if (push_mid || flush_push) begin
            m_vld_next  = 1'b1;
            m_slot_next = pend_slot_reg;
            m_tag_next  = pend_tag_reg;
            m_last_next = flush_push;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            armed_reg    <= '0;
            rd_cnt_reg   <= '0;
            ev_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            armed_reg    <= armed_next;
            rd_cnt_reg   <= rd_cnt_next;
            ev_vld_reg   <= ev_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_idx_reg    <= ev_idx_next;
        now_reg       <= now_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        m_slot_reg    <= m_slot_next;
        m_tag_reg     <= m_tag_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(OUT_W - OUT_RAW_W)'(0), m_tag_reg, m_slot_reg};

`ifndef NO_ASSERTIONS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!pend_vld_reg && !ev_vld_reg))
        else $error("held result or evaluation left over outside a scan");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_cnt_reg <= CNT_W'(SLOTS))
        else $error("scan read counter beyond the table");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_push |=> (m_tvalid && m_tlast))
        else $error("end of scan did not deliver a final result");

    a_expire_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && expired) |=> !armed_reg[$past(ev_idx_reg)])
        else $error("expired slot still armed");

    a_mid_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push_mid |=> (m_tvalid && !m_tlast))
        else $error("result inside a scan marked as last");
`endif

endmodule

// ===== sv/tte_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. No dependencies.
`timescale 1ns / 1ps

module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== sv/tte_cmp.sv =====
// Expiry compare unit, shared by every slot of a scan: forms start plus
// interval in one extra bit and compares it with the current time. Uses tte_pkg.
`timescale 1ns / 1ps

module tte_cmp (
    input  logic [tte_pkg::TIME_W-1:0] start,
    input  logic [tte_pkg::IVL_W-1:0]  ivl,
    input  logic [tte_pkg::TIME_W-1:0] now,
    output logic                       hit
);
    import tte_pkg::*;

    logic [TIME_W:0] end_time;

    // The sum cannot wrap, so a late start never looks expired.
    assign end_time = {1'b0, start} + (TIME_W + 1)'(ivl);
    assign hit      = (end_time <= {1'b0, now});

endmodule
